[rtl/zone_range_match_table_assert.svh]
// Assertion macros for the zone range match table.
`ifndef ZONE_RANGE_MATCH_TABLE_ASSERT_SVH
`define ZONE_RANGE_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ZRMT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ZRMT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/zrmt_pkg.sv]
// Shared types, widths and codes for the zone range match table.
`default_nettype none

package zrmt_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned VAL_W        = 7;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned START_W      = 7;
  localparam int unsigned ZONE_INDEX_W = 6;

  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 2'd1;
  localparam logic [OP_W-1:0] OP_INTERSECT = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_VEL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [VAL_W-1:0]    klo;
    logic [VAL_W-1:0]    khi;
    logic [VAL_W-1:0]    vlo;
    logic [VAL_W-1:0]    vhi;
    logic [SAMPLE_W-1:0] smp;
  } zone_t;

  typedef struct packed {
    logic  match;
    logic  keep;
    zone_t narrowed;
  } zone_eval_t;

endpackage

`default_nettype wire

[rtl/zrmt_zone_mem.sv]
// Zone table storage: one write port, one read port with registered data.
`default_nettype none

module zrmt_zone_mem import zrmt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  zone_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output zone_t         rdata
);

  zone_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/zrmt_zone_eval.sv]
// Per-entry zone logic: query match, channel keep test and range narrowing.
`default_nettype none

module zrmt_zone_eval import zrmt_pkg::*; (
  input  zone_t             zone,
  input  logic [CHAN_W-1:0] channel,
  input  logic [VAL_W-1:0]  note,
  input  logic [VAL_W-1:0]  velocity,
  input  logic              kind,
  input  logic [VAL_W-1:0]  bound_lo,
  input  logic [VAL_W-1:0]  bound_hi,
  output zone_eval_t        result
);

  always_comb begin
    result.keep  = (zone.chan != channel);
    result.match = (zone.chan == channel) &&
                   (note >= zone.klo) && (note <= zone.khi) &&
                   (velocity >= zone.vlo) && (velocity <= zone.vhi);
    result.narrowed = zone;
    if (kind == KIND_KEY) begin
      if (bound_lo > zone.klo) result.narrowed.klo = bound_lo;
      if (bound_hi < zone.khi) result.narrowed.khi = bound_hi;
    end else begin
      if (bound_lo > zone.vlo) result.narrowed.vlo = bound_lo;
      if (bound_hi < zone.vhi) result.narrowed.vhi = bound_hi;
    end
  end

endmodule

`default_nettype wire

[rtl/zone_range_match_table.sv]
// Top level of the zone range match table: sequencer around the zone memory.
//
// Input channel (in_valid/in_stall) takes one command per transfer: clear a
// channel, append a zone, intersect a range from start_index on, or query.
// Output channel (out_valid/out_stall) carries the results from a register.
// Append passes through the finish state and then loads its status result.
// Clear, intersect and query scan the table through the single read port of
// the zone memory, one entry per cycle while no query match waits on the
// output register, with registered read data. Commands are taken one at a
// time; in_stall is high from the transfer until the final result is loaded.
// Query results come newest zone first; last marks the oldest match, and a
// query without a match gives one result with hit low.
// A stalled receiver holds the output register; a query scan pauses when a
// further match finds that register still occupied.
// Reset empties the table (zone count zero); entry contents are left as is.
`default_nettype none
`include "zone_range_match_table_assert.svh"

module zone_range_match_table import zrmt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         opcode,
  input  logic [CHAN_W-1:0]       channel,
  input  logic [VAL_W-1:0]        note,
  input  logic [VAL_W-1:0]        velocity,
  input  logic [VAL_W-1:0]        key_low,
  input  logic [VAL_W-1:0]        key_high,
  input  logic [VAL_W-1:0]        vel_low,
  input  logic [VAL_W-1:0]        vel_high,
  input  logic [SAMPLE_W-1:0]     sample_ref,
  input  logic                    range_kind,
  input  logic [START_W-1:0]      start_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ZONE_INDEX_W-1:0] zone_index,
  output logic [SAMPLE_W-1:0]     zone_sample,
  output logic                    hit,
  output logic                    last,
  output logic                    full_error
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic                rd_valid;
  logic                pend_valid;

  logic [OP_W-1:0]     op;
  logic [CHAN_W-1:0]   chan;
  logic [VAL_W-1:0]    note_q;
  logic [VAL_W-1:0]    vel_q;
  logic                kind;
  logic [VAL_W-1:0]    bound_lo;
  logic [VAL_W-1:0]    bound_hi;
  logic                err_flag;
  logic [AW-1:0]       ptr;
  logic [CW-1:0]       left;
  logic [CW-1:0]       wptr;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       pend_idx;
  logic [SAMPLE_W-1:0] pend_smp;

  logic                in_accept;
  logic                full;
  logic                out_free;
  logic                eval_ok;
  logic                consume;
  logic                issue;
  logic                ev_take;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  zone_t               mem_wdata;
  zone_t               rdata;
  zone_eval_t          ev;

  logic                    out_push;
  logic [ZONE_INDEX_W-1:0] push_idx;
  logic [SAMPLE_W-1:0]     push_smp;
  logic                    push_hit;
  logic                    push_last;
  logic                    push_err;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count == FULL_COUNT);
  assign out_free  = !out_valid || !out_stall;

  zrmt_zone_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (ptr),
    .rdata (rdata)
  );

  zrmt_zone_eval u_eval (
    .zone     (rdata),
    .channel  (chan),
    .note     (note_q),
    .velocity (vel_q),
    .kind     (kind),
    .bound_lo (bound_lo),
    .bound_hi (bound_hi),
    .result   (ev)
  );

  always_comb begin
    eval_ok = !((op == OP_QUERY) && ev.match && pend_valid && !out_free);
    consume = !rd_valid || eval_ok;
    issue   = (state == ST_SCAN) && (left != '0) && consume;
    ev_take = (state == ST_SCAN) && rd_valid && eval_ok;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = ev.narrowed;
    if (in_accept && (opcode == OP_APPEND) && !full) begin
      mem_we         = 1'b1;
      mem_waddr      = count[AW-1:0];
      mem_wdata.chan = channel;
      mem_wdata.klo  = key_low;
      mem_wdata.khi  = key_high;
      mem_wdata.vlo  = vel_low;
      mem_wdata.vhi  = vel_high;
      mem_wdata.smp  = sample_ref;
    end else if (ev_take && (op == OP_CLEAR) && ev.keep) begin
      mem_we    = 1'b1;
      mem_waddr = wptr[AW-1:0];
      mem_wdata = rdata;
    end else if (ev_take && (op == OP_INTERSECT)) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    out_push  = 1'b0;
    push_idx  = ZONE_INDEX_W'(pend_idx);
    push_smp  = pend_smp;
    push_hit  = 1'b1;
    push_last = 1'b0;
    push_err  = 1'b0;
    if (ev_take && (op == OP_QUERY) && ev.match && pend_valid) begin
      out_push = 1'b1;
    end else if ((state == ST_FINISH) && out_free) begin
      out_push  = 1'b1;
      push_last = 1'b1;
      push_err  = err_flag;
      if (!((op == OP_QUERY) && pend_valid)) begin
        push_idx = '0;
        push_smp = '0;
        push_hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pend_valid <= 1'b0;
            unique case (opcode) inside
              OP_APPEND: begin
                if (!full) count <= count + 1'b1;
                state <= ST_FINISH;
              end
              OP_CLEAR, OP_INTERSECT, OP_QUERY: begin
                state <= ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (consume) rd_valid <= issue;
          if (ev_take && (op == OP_QUERY) && ev.match) pend_valid <= 1'b1;
          if ((left == '0) && consume) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state      <= ST_IDLE;
            pend_valid <= 1'b0;
            if (op == OP_CLEAR) count <= wptr;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op       <= opcode;
      chan     <= channel;
      note_q   <= note;
      vel_q    <= velocity;
      kind     <= range_kind;
      bound_lo <= (range_kind == KIND_KEY) ? key_low : vel_low;
      bound_hi <= (range_kind == KIND_KEY) ? key_high : vel_high;
      err_flag <= (opcode == OP_APPEND) && full;
      wptr     <= '0;
      unique case (opcode) inside
        OP_INTERSECT: begin
          ptr  <= start_index[AW-1:0];
          left <= (START_W'(count) > start_index) ?
                  CW'(START_W'(count) - start_index) : '0;
        end
        OP_QUERY: begin
          ptr  <= AW'(count - 1'b1);
          left <= count;
        end
        OP_CLEAR, OP_APPEND: begin
          ptr  <= '0;
          left <= count;
        end
        default: begin
          ptr  <= '0;
          left <= '0;
        end
      endcase
    end else if (issue) begin
      ptr  <= (op == OP_QUERY) ? ptr - 1'b1 : ptr + 1'b1;
      left <= left - 1'b1;
    end
    if (issue) rd_addr <= ptr;
    if (ev_take && (op == OP_CLEAR) && ev.keep) wptr <= wptr + 1'b1;
    if (ev_take && (op == OP_QUERY) && ev.match) begin
      pend_idx <= rd_addr;
      pend_smp <= rdata.smp;
    end
    if (out_push) begin
      zone_index  <= push_idx;
      zone_sample <= push_smp;
      hit         <= push_hit;
      last        <= push_last;
      full_error  <= push_err;
    end
  end

  `ZRMT_CHECK(a_push_free, out_push, out_free, "result loaded over an untaken transfer")
  `ZRMT_CHECK(a_clear_order, (state == ST_SCAN) && (op == OP_CLEAR) && mem_we, wptr <= CW'(rd_addr), "compaction write ahead of read")
  `ZRMT_CHECK_NEXT(a_full_hold, in_accept && (opcode == OP_APPEND) && full, count == $past(count), "count moved on dropped append")
  `ZRMT_CHECK(a_finish_quiet, state == ST_FINISH, !mem_we && !issue, "memory access while finishing")
  `ZRMT_CHECK(a_rd_scan, rd_valid, state == ST_SCAN, "read data pending outside a scan")
  `ZRMT_CHECK(a_count_bound, 1'b1, count <= FULL_COUNT, "zone count beyond table depth")

endmodule

`default_nettype wire
